### hw/rtl/assert_macros.svh
// assertion macros shared by the mandelbrot escape-time rtl
// no dependencies; the assertions are left out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define MBE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mbe assertion failed");

// expression must never be true outside reset
`define MBE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mbe assertion failed");

`else

`define MBE_ASSERT(lbl, prop)
`define MBE_ASSERT_NEVER(lbl, expr)

`endif

`endif

### hw/rtl/mbe_pkg.sv
// types, constants and fixed-point helpers for the mandelbrot escape-time block
// no dependencies
package mbe_pkg;

  localparam int unsigned CW         = 32;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned ITER_WIDTH = 16;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned SPAN_W     = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned JQ_DEPTH   = 2;

  // quotient bits of the divider and the shift that decides saturation
  localparam int unsigned QW        = CW - 1;
  localparam int unsigned SAT_SHIFT = QW - FRAC_BITS;
  localparam int unsigned MAG_W     = 2 * CW - FRAC_BITS;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [QW-1:0]        QMAX = {QW{1'b1}};
  localparam logic signed [CW-1:0] HALF = CW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [CW:0]          FOUR = (CW+1)'(64'd4 << FRAC_BITS);
  localparam logic [MAG_W-1:0]     MAG_MAXP = MAG_W'(CMAX);
  localparam logic [MAG_W-1:0]     MAG_MAXN = MAG_W'(1) << (CW - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_SPAN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_FACTOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd6;

  localparam logic signed [CW-1:0]   RST_CENTER_REAL     = '0;
  localparam logic signed [CW-1:0]   RST_CENTER_IMAG     = '0;
  localparam logic [SPAN_W-1:0]      RST_ZOOM_SPAN       = 31'd805306368;
  localparam logic [SPAN_W-1:0]      RST_ASPECT_FACTOR   = 31'd268435456;
  localparam logic [DIM_W-1:0]       RST_FRAME_WIDTH     = 13'd640;
  localparam logic [DIM_W-1:0]       RST_FRAME_HEIGHT    = 13'd480;
  localparam logic [ITER_WIDTH-1:0]  RST_ITERATION_LIMIT = 16'd1000;

  typedef struct packed {
    logic [COL_W-1:0] pixel_column;
    logic [COL_W-1:0] pixel_row;
  } pix_t;

  typedef struct packed {
    logic [COL_W-1:0]      out_column;
    logic [COL_W-1:0]      out_row;
    logic [ITER_WIDTH-1:0] iteration_count;
  } res_t;

  typedef struct packed {
    logic signed [CW-1:0]  center_real;
    logic signed [CW-1:0]  center_imag;
    logic [SPAN_W-1:0]     zoom_span;
    logic [SPAN_W-1:0]     aspect_factor;
    logic [DIM_W-1:0]      frame_width;
    logic [DIM_W-1:0]      frame_height;
    logic [ITER_WIDTH-1:0] iteration_limit;
  } cfg_t;

  // mapped point handed from the front to the iteration engine
  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic [COL_W-1:0]     row;
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] ci;
  } job_t;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] num;
    logic [QW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? CMIN : CMAX;
    end
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mag_of(input logic signed [CW-1:0] a);
    logic [CW-1:0] u;
    u = a;
    return u[CW-1] ? (~u + CW'(1)) : u;
  endfunction

  // scale a magnitude product back to the fixed-point grid, apply sign, saturate
  function automatic logic signed [CW-1:0] mul_fin(input logic [2*CW-1:0] prod,
                                                   input logic neg);
    logic [MAG_W-1:0] mag;
    logic [CW-1:0]    low;
    mag = prod[2*CW-1:FRAC_BITS];
    low = mag[CW-1:0];
    if (!neg) begin
      if (mag > MAG_MAXP) begin
        return CMAX;
      end
      return $signed(low);
    end
    if (mag > MAG_MAXN) begin
      return CMIN;
    end
    return $signed(~low + CW'(1));
  endfunction

  // zero acts as one, anything above the largest frame acts as the largest frame
  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end
    if (d > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

### hw/rtl/mbe_divider.sv
// restoring fixed-point divider: floor(num * 2^FRAC_BITS / den), saturated
// depends on mbe_pkg
module mbe_divider import mbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sat_q, sat_d;
  logic [QW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    sh_q, sh_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [QW-1:0]    den_q, den_d;
  logic [QW:0]      part;
  logic [QW:0]      diff;
  logic             ge;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sat_d  = sat_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    den_d  = den_q;
    part   = {rem_q, sh_q[QW-1]};
    diff   = part - {1'b0, den_q};
    ge     = part >= {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QW);
      // quotient overflows the signed range exactly when num / 2^SAT_SHIFT >= den
      sat_d  = (req_i.num >> SAT_SHIFT) >= req_i.den;
      rem_d  = req_i.num >> SAT_SHIFT;
      sh_d   = req_i.num << FRAC_BITS;
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = ge ? diff[QW-1:0] : part[QW-1:0];
        quo_d = {quo_q[QW-2:0], ge};
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quot = sat_q ? QMAX : quo_q;

endmodule

### hw/rtl/mbe_job_queue.sv
// short queue of mapped points between the front and the iteration engine
// depends on mbe_pkg
module mbe_job_queue import mbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(JQ_DEPTH + 1);

  job_t             mem_q [JQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = cnt_q == CNT_W'(JQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/mbe_front.sv
// front end: takes a pixel and maps it to the point c of the complex plane
// depends on mbe_pkg, mbe_divider (through its request/response ports), assert_macros.svh
`include "assert_macros.svh"

module mbe_front import mbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push_i,
  input  pix_t     pix_i,
  output logic     full_o,
  output logic     job_push_o,
  input  logic     job_full_i,
  output job_t     job_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i
);

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_ZX   = 4'd1;
  localparam logic [3:0] F_ZX2  = 4'd2;
  localparam logic [3:0] F_DZ   = 4'd3;
  localparam logic [3:0] F_DX   = 4'd4;
  localparam logic [3:0] F_DY   = 4'd5;
  localparam logic [3:0] F_MX   = 4'd6;
  localparam logic [3:0] F_CX   = 4'd7;
  localparam logic [3:0] F_CY   = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [COL_W-1:0]     row_q, row_d;
  logic [2*CW-1:0]      prod_q, prod_d;
  logic signed [CW-1:0] zx_q, zx_d;
  logic signed [CW-1:0] zy_q, zy_d;
  logic signed [CW-1:0] tx_q, tx_d;
  logic signed [CW-1:0] ty_q, ty_d;
  logic signed [CW-1:0] cr_q, cr_d;

  logic [SPAN_W-1:0]    asp_eff;
  logic [DIM_W-1:0]     dim_w, dim_h;
  logic [CW-1:0]        mul_a, mul_b;
  logic signed [CW-1:0] t_new;
  logic signed [CW-1:0] ci_w;
  logic                 div_wait;

  assign asp_eff = (cfg_i.aspect_factor == '0) ? SPAN_W'(1) : cfg_i.aspect_factor;
  assign dim_w   = dim_of(cfg_i.frame_width);
  assign dim_h   = dim_of(cfg_i.frame_height);
  // pos / dim - 1/2
  assign t_new   = $signed({1'b0, div_rsp_i.quot}) - HALF;
  assign ci_w    = sat_add(cfg_i.center_imag, mul_fin(prod_q, ty_q[CW-1]));

  assign full_o     = state_q != F_IDLE;
  assign job_push_o = (state_q == F_CY) && !job_full_i;
  assign job_o      = '{col: col_q, row: row_q, cr: cr_q, ci: ci_w};
  assign div_wait   = state_q inside {F_DZ, F_DX, F_DY};

  // one shared multiplier: zoom*aspect, then x span * |tx|, then y span * |ty|
  always_comb begin
    case (state_q)
      F_MX: begin
        mul_a = zx_q;
        mul_b = mag_of(tx_q);
      end
      F_CX: begin
        mul_a = zy_q;
        mul_b = mag_of(ty_q);
      end
      default: begin
        mul_a = CW'(cfg_i.zoom_span);
        mul_b = CW'(asp_eff);
      end
    endcase
  end

  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = '0;
    div_req_o.den   = '0;
    case (state_q)
      F_ZX2: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = cfg_i.zoom_span;
        div_req_o.den   = asp_eff;
      end
      F_DZ: begin
        div_req_o.start = div_rsp_i.done;
        div_req_o.num   = QW'(col_q);
        div_req_o.den   = QW'(dim_w);
      end
      F_DX: begin
        div_req_o.start = div_rsp_i.done;
        div_req_o.num   = QW'(row_q);
        div_req_o.den   = QW'(dim_h);
      end
      default: begin
        div_req_o.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    prod_d  = prod_q;
    zx_d    = zx_q;
    zy_d    = zy_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    cr_d    = cr_q;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          col_d   = pix_i.pixel_column;
          row_d   = pix_i.pixel_row;
          state_d = F_ZX;
        end
      end
      F_ZX: begin
        prod_d  = (2*CW)'(mul_a) * (2*CW)'(mul_b);
        state_d = F_ZX2;
      end
      F_ZX2: begin
        zx_d    = mul_fin(prod_q, 1'b0);
        state_d = F_DZ;
      end
      F_DZ: begin
        if (div_rsp_i.done) begin
          zy_d    = $signed({1'b0, div_rsp_i.quot});
          state_d = F_DX;
        end
      end
      F_DX: begin
        if (div_rsp_i.done) begin
          tx_d    = t_new;
          state_d = F_DY;
        end
      end
      F_DY: begin
        if (div_rsp_i.done) begin
          ty_d    = t_new;
          state_d = F_MX;
        end
      end
      F_MX: begin
        prod_d  = (2*CW)'(mul_a) * (2*CW)'(mul_b);
        state_d = F_CX;
      end
      F_CX: begin
        cr_d    = sat_add(cfg_i.center_real, mul_fin(prod_q, tx_q[CW-1]));
        prod_d  = (2*CW)'(mul_a) * (2*CW)'(mul_b);
        state_d = F_CY;
      end
      F_CY: begin
        if (!job_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    prod_q <= prod_d;
    zx_q   <= zx_d;
    zy_q   <= zy_d;
    tx_q   <= tx_d;
    ty_q   <= ty_d;
    cr_q   <= cr_d;
  end

  `MBE_ASSERT(a_accept_starts, push_i && !full_o |=> state_q == F_ZX)
  `MBE_ASSERT(a_free_after_handoff, $fell(full_o) |-> $past(job_push_o))
  `MBE_ASSERT(a_div_done_waited, div_rsp_i.done |-> div_wait)

endmodule

### hw/rtl/mbe_iter.sv
// back end: iterates z = z^2 + c for one point and holds the finished result
// depends on mbe_pkg, assert_macros.svh
`include "assert_macros.svh"

module mbe_iter import mbe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ITER_WIDTH-1:0] iter_limit_i,
  input  logic                  job_empty_i,
  input  job_t                  job_i,
  output logic                  job_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output res_t                  res_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_UPD  = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [ITER_WIDTH-1:0] n_q, n_d;
  logic signed [CW-1:0]  x_q, x_d;
  logic signed [CW-1:0]  y_q, y_d;
  job_t                  job_q, job_d;
  logic [2*CW-1:0]       pxx_q, pxx_d;
  logic [2*CW-1:0]       pyy_q, pyy_d;
  logic [2*CW-1:0]       pxy_q, pxy_d;
  logic                  nxy_q, nxy_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;

  logic [CW-1:0]         ax, ay;
  logic signed [CW-1:0]  x2, y2, xy;
  logic [CW:0]           mag_sum;
  logic                  escaped;
  logic [ITER_WIDTH-1:0] n_inc;
  logic                  ld_res;

  assign ax      = mag_of(x_q);
  assign ay      = mag_of(y_q);
  assign x2      = mul_fin(pxx_q, 1'b0);
  assign y2      = mul_fin(pyy_q, 1'b0);
  assign xy      = mul_fin(pxy_q, nxy_q);
  assign mag_sum = {1'b0, x2} + {1'b0, y2};
  assign escaped = mag_sum > FOUR;
  assign n_inc   = n_q + ITER_WIDTH'(1);

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign ld_res    = (state_q == B_FIN) && (!out_valid_q || pop_i);
  assign empty_o   = !out_valid_q;
  assign res_o     = res_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    x_d         = x_q;
    y_d         = y_q;
    job_d       = job_q;
    pxx_d       = pxx_q;
    pyy_d       = pyy_q;
    pxy_d       = pxy_q;
    nxy_d       = nxy_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_d   = job_i;
          x_d     = '0;
          y_d     = '0;
          n_d     = '0;
          state_d = (iter_limit_i == '0) ? B_FIN : B_MUL;
        end
      end
      B_MUL: begin
        pxx_d   = (2*CW)'(ax) * (2*CW)'(ax);
        pyy_d   = (2*CW)'(ay) * (2*CW)'(ay);
        pxy_d   = (2*CW)'(ax) * (2*CW)'(ay);
        nxy_d   = x_q[CW-1] != y_q[CW-1];
        state_d = B_UPD;
      end
      B_UPD: begin
        if (escaped) begin
          state_d = B_FIN;
        end else begin
          y_d     = sat_add(sat_add(xy, xy), job_q.ci);
          // both squares are non-negative, so the difference cannot overflow
          x_d     = sat_add(x2 - y2, job_q.cr);
          n_d     = n_inc;
          state_d = (n_inc < iter_limit_i) ? B_MUL : B_FIN;
        end
      end
      B_FIN: begin
        if (ld_res) begin
          res_d       = '{out_column: job_q.col, out_row: job_q.row, iteration_count: n_q};
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    x_q   <= x_d;
    y_q   <= y_d;
    job_q <= job_d;
    pxx_q <= pxx_d;
    pyy_q <= pyy_d;
    pxy_q <= pxy_d;
    nxy_q <= nxy_d;
    res_q <= res_d;
  end

  `MBE_ASSERT(a_upd_after_mul, (state_q == B_UPD) |-> ($past(state_q) == B_MUL))
  `MBE_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> ($past(state_q) == B_FIN))
  `MBE_ASSERT(a_job_starts, job_pop_o |=> (state_q == B_MUL || state_q == B_FIN))

endmodule

### hw/rtl/mandelbrot_escape_time.sv
// mandelbrot escape-time evaluator: a result takes longer the higher its count n; a new
// pixel is taken once the front has handed the previous point to the queue; the pixel rate
// is set by three 31-step divisions and by the B_MUL/B_UPD loop, one pass per iteration
// front and iteration engine overlap through a two-entry point queue
// reset clears control state and loads the register defaults; no clearing pass
// depends on mbe_pkg, mbe_divider, mbe_front, mbe_job_queue, mbe_iter
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  pix_t                  in_data_i,
  input  logic                  pop,
  output logic                  empty,
  output res_t                  out_data_o
);

  cfg_t     cfg_q, cfg_d;
  div_req_t div_req;
  div_rsp_t div_rsp;
  job_t     front_job, queue_job;
  logic     job_push, job_full, job_pop, job_empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CENTER_REAL:     cfg_d.center_real     = $signed(cfg_data_i[CW-1:0]);
        REG_CENTER_IMAG:     cfg_d.center_imag     = $signed(cfg_data_i[CW-1:0]);
        REG_ZOOM_SPAN:       cfg_d.zoom_span       = cfg_data_i[SPAN_W-1:0];
        REG_ASPECT_FACTOR:   cfg_d.aspect_factor   = cfg_data_i[SPAN_W-1:0];
        REG_FRAME_WIDTH:     cfg_d.frame_width     = cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:    cfg_d.frame_height    = cfg_data_i[DIM_W-1:0];
        REG_ITERATION_LIMIT: cfg_d.iteration_limit = cfg_data_i[ITER_WIDTH-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_real     <= RST_CENTER_REAL;
      cfg_q.center_imag     <= RST_CENTER_IMAG;
      cfg_q.zoom_span       <= RST_ZOOM_SPAN;
      cfg_q.aspect_factor   <= RST_ASPECT_FACTOR;
      cfg_q.frame_width     <= RST_FRAME_WIDTH;
      cfg_q.frame_height    <= RST_FRAME_HEIGHT;
      cfg_q.iteration_limit <= RST_ITERATION_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mbe_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .pix_i      (in_data_i),
    .full_o     (full),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_o      (front_job),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  mbe_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (front_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (queue_job),
    .empty_o (job_empty)
  );

  mbe_iter u_iter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .iter_limit_i (cfg_q.iteration_limit),
    .job_empty_i  (job_empty),
    .job_i        (queue_job),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .res_o        (out_data_o)
  );

endmodule
